[rtl/pwsw_pkg.sv]
// Shared types, register codes and reset values for the pulse-width single-wire transmitter.
package pwsw_pkg;

    localparam int BUFFER_BYTES_DEFAULT = 16;

    localparam int TICK_W = 16;
    localparam int BYTE_W = 8;
    localparam int PULSE_W = 16;
    localparam int GAP_W = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int ELAPSED_W = GAP_W;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PUSH = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_LOW = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_PULSE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PULSE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_END_GAP = 2'd3;

    localparam logic [PULSE_W-1:0] HEADER_LOW_RESET = 16'd4000;
    localparam logic [PULSE_W-1:0] SHORT_PULSE_RESET = 16'd800;
    localparam logic [PULSE_W-1:0] LONG_PULSE_RESET = 16'd2400;
    localparam logic [GAP_W-1:0] END_GAP_RESET = 20'd100000;

    typedef struct packed {
        logic [PULSE_W-1:0] header_low_us;
        logic [PULSE_W-1:0] short_pulse_us;
        logic [PULSE_W-1:0] long_pulse_us;
        logic [GAP_W-1:0]   end_gap_us;
    } t_timing;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic byte_dropped;
    } t_result;

endpackage

[rtl/pwsw_buffer.sv]
// Transmit byte buffer with one write port and one registered read port.
module pwsw_buffer #(
    parameter int BUFFER_BYTES = pwsw_pkg::BUFFER_BYTES_DEFAULT,
    parameter int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [pwsw_pkg::BYTE_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [pwsw_pkg::BYTE_W-1:0] o_rdata
);

    logic [pwsw_pkg::BYTE_W-1:0] r_mem [BUFFER_BYTES];
    logic [pwsw_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // A write to the address being read shows the new byte on the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pwsw_sequencer.sv]
// Frame sequencer: buffer fill, phase timing and line level.
module pwsw_sequencer #(
    parameter int BUFFER_BYTES = pwsw_pkg::BUFFER_BYTES_DEFAULT,
    parameter int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1,
    parameter int PW = $clog2(BUFFER_BYTES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_opcode,
    input  logic [pwsw_pkg::TICK_W-1:0] i_tick_us,
    input  logic [pwsw_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_last_byte,
    input  pwsw_pkg::t_timing           i_timing,
    input  logic [pwsw_pkg::BYTE_W-1:0] i_rdata,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [pwsw_pkg::BYTE_W-1:0] o_wdata,
    output logic [AW-1:0]               o_raddr,
    output pwsw_pkg::t_result           o_result
);

    localparam int EW = pwsw_pkg::ELAPSED_W;
    localparam logic [PW-1:0] DEPTH = PW'(BUFFER_BYTES);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_BIT_HIGH = 3'd2;
    localparam logic [2:0] PH_BIT_LOW = 3'd3;
    localparam logic [2:0] PH_END_GAP = 3'd4;

    logic [2:0]    r_phase, n_phase;
    logic [PW-1:0] r_byte_total, n_byte_total;
    logic [PW-1:0] r_byte_pos, n_byte_pos;
    logic [2:0]    r_bit_pos, n_bit_pos;
    logic [EW-1:0] r_elapsed, n_elapsed;
    logic          r_level, n_level;
    logic [pwsw_pkg::PULSE_W-1:0] r_low_short, n_low_short;
    logic [pwsw_pkg::PULSE_W-1:0] r_low_long, n_low_long;

    logic [EW:0]   sum;
    logic [EW-1:0] elapsed_sat;
    logic          cur_bit;
    logic [pwsw_pkg::PULSE_W-1:0] high_us;
    logic [pwsw_pkg::PULSE_W-1:0] low_us;
    logic          done;
    logic          dropped;

    // Both low lengths are captured when a bit starts; the bit value picks one later.
    assign cur_bit = i_rdata[r_bit_pos];
    assign high_us = cur_bit ? i_timing.long_pulse_us : i_timing.short_pulse_us;
    assign low_us = cur_bit ? r_low_short : r_low_long;
    assign sum = {1'b0, r_elapsed} + {{(EW + 1 - pwsw_pkg::TICK_W){1'b0}}, i_tick_us};
    assign elapsed_sat = sum[EW] ? {EW{1'b1}} : sum[EW-1:0];

    always_comb begin
        n_phase = r_phase;
        n_byte_total = r_byte_total;
        n_byte_pos = r_byte_pos;
        n_bit_pos = r_bit_pos;
        n_elapsed = r_elapsed;
        n_level = r_level;
        n_low_short = r_low_short;
        n_low_long = r_low_long;
        done = 1'b0;
        dropped = 1'b0;
        o_we = 1'b0;
        o_waddr = r_byte_total[AW-1:0];
        o_wdata = i_data_byte;
        if (i_accept) begin
            if (i_opcode == pwsw_pkg::OP_PUSH) begin
                if (r_phase != PH_IDLE) begin
                    dropped = 1'b1;
                end else begin
                    if (r_byte_total < DEPTH) begin
                        o_we = 1'b1;
                        n_byte_total = r_byte_total + PW'(1);
                    end else begin
                        dropped = 1'b1;
                    end
                    if (i_last_byte && (n_byte_total != '0)) begin
                        n_byte_pos = '0;
                        n_bit_pos = '0;
                        n_phase = PH_HEADER;
                        n_level = 1'b0;
                        n_elapsed = '0;
                    end
                end
            end else if (r_phase != PH_IDLE) begin
                n_elapsed = elapsed_sat;
                unique case (r_phase)
                    PH_HEADER: begin
                        if (elapsed_sat >= EW'(i_timing.header_low_us)) begin
                            n_phase = PH_BIT_HIGH;
                            n_level = 1'b1;
                            n_elapsed = '0;
                            n_low_short = i_timing.short_pulse_us;
                            n_low_long = i_timing.long_pulse_us;
                        end
                    end
                    PH_BIT_HIGH: begin
                        if (elapsed_sat >= EW'(high_us)) begin
                            n_phase = PH_BIT_LOW;
                            n_level = 1'b0;
                            n_elapsed = '0;
                        end
                    end
                    PH_BIT_LOW: begin
                        if (elapsed_sat >= EW'(low_us)) begin
                            n_level = 1'b1;
                            n_elapsed = '0;
                            n_phase = PH_BIT_HIGH;
                            n_low_short = i_timing.short_pulse_us;
                            n_low_long = i_timing.long_pulse_us;
                            n_bit_pos = r_bit_pos + 3'd1;
                            if (r_bit_pos == 3'd7) begin
                                n_byte_pos = r_byte_pos + PW'(1);
                                if ((r_byte_pos + PW'(1)) >= r_byte_total) begin
                                    n_phase = PH_END_GAP;
                                end
                            end
                        end
                    end
                    PH_END_GAP: begin
                        if (elapsed_sat >= i_timing.end_gap_us) begin
                            n_phase = PH_IDLE;
                            n_level = 1'b1;
                            n_elapsed = '0;
                            n_byte_total = '0;
                            n_byte_pos = '0;
                            n_bit_pos = '0;
                            done = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_level = 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_raddr = n_byte_pos[AW-1:0];

    always_comb begin
        o_result.line_level = n_level;
        o_result.busy_res = (n_phase != PH_IDLE);
        o_result.frame_done = done;
        o_result.byte_dropped = dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_byte_total <= '0;
            r_byte_pos <= '0;
            r_bit_pos <= '0;
            r_elapsed <= '0;
            r_level <= 1'b1;
            r_low_short <= '0;
            r_low_long <= '0;
        end else begin
            r_phase <= n_phase;
            r_byte_total <= n_byte_total;
            r_byte_pos <= n_byte_pos;
            r_bit_pos <= n_bit_pos;
            r_elapsed <= n_elapsed;
            r_level <= n_level;
            r_low_short <= n_low_short;
            r_low_long <= n_low_long;
        end
    end

endmodule

[rtl/pulse_width_single_wire_transmitter_top.sv]
// Top level of the pulse-width single-wire transmitter: handshake, registers, result register.
// The block takes one transaction per clock: a tick or a byte push is handled in the
// cycle it is accepted and its result sits in a one-entry output register, so input is
// stalled only while that register holds a result the consumer has not taken. Each
// transaction yields exactly one result, valid in the cycle after acceptance. The byte buffer is
// a memory whose read port follows the byte being sent, so no clearing pass is needed.
module pulse_width_single_wire_transmitter_top #(
    parameter int BUFFER_BYTES = pwsw_pkg::BUFFER_BYTES_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_opcode,
    input  logic [pwsw_pkg::TICK_W-1:0]     i_tick_us,
    input  logic [pwsw_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                            i_last_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_line_level,
    output logic                            o_busy_res,
    output logic                            o_frame_done,
    output logic                            o_byte_dropped,
    input  logic                            i_cfg_we,
    input  logic [pwsw_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pwsw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int PW = $clog2(BUFFER_BYTES + 1);

    pwsw_pkg::t_timing r_timing;
    pwsw_pkg::t_result r_out;
    pwsw_pkg::t_result result;
    logic              r_out_valid;
    logic              accept;

    logic                        we;
    logic [AW-1:0]               waddr;
    logic [pwsw_pkg::BYTE_W-1:0] wdata;
    logic [AW-1:0]               raddr;
    logic [pwsw_pkg::BYTE_W-1:0] rdata;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.header_low_us <= pwsw_pkg::HEADER_LOW_RESET;
            r_timing.short_pulse_us <= pwsw_pkg::SHORT_PULSE_RESET;
            r_timing.long_pulse_us <= pwsw_pkg::LONG_PULSE_RESET;
            r_timing.end_gap_us <= pwsw_pkg::END_GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pwsw_pkg::REG_HEADER_LOW: begin
                    r_timing.header_low_us <= i_cfg_data[pwsw_pkg::PULSE_W-1:0];
                end
                pwsw_pkg::REG_SHORT_PULSE: begin
                    r_timing.short_pulse_us <= i_cfg_data[pwsw_pkg::PULSE_W-1:0];
                end
                pwsw_pkg::REG_LONG_PULSE: begin
                    r_timing.long_pulse_us <= i_cfg_data[pwsw_pkg::PULSE_W-1:0];
                end
                pwsw_pkg::REG_END_GAP: begin
                    r_timing.end_gap_us <= i_cfg_data[pwsw_pkg::GAP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    pwsw_buffer #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .AW(AW)
    ) u_buffer (
        .i_clk(i_clk),
        .i_we(we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    pwsw_sequencer #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .AW(AW),
        .PW(PW)
    ) u_sequencer (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_accept(accept),
        .i_opcode(i_opcode),
        .i_tick_us(i_tick_us),
        .i_data_byte(i_data_byte),
        .i_last_byte(i_last_byte),
        .i_timing(r_timing),
        .i_rdata(rdata),
        .o_we(we),
        .o_waddr(waddr),
        .o_wdata(wdata),
        .o_raddr(raddr),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_line_level = r_out.line_level;
    assign o_busy_res = r_out.busy_res;
    assign o_frame_done = r_out.frame_done;
    assign o_byte_dropped = r_out.byte_dropped;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> (o_line_level && !o_busy_res))
        else $error("Frame completion reported while still busy or line low.");

    a_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_busy_res) |-> o_line_level)
        else $error("Line driven low while no frame is in progress.");

    a_drop_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_dropped) |-> !o_frame_done)
        else $error("A dropped byte transaction also completed a frame.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_out)))
        else $error("Stalled result changed before it was taken.");
`endif

endmodule
